@@ design/dps_pkg.sv @@
// Shared types and constants of the dynamic priority scheduler.
package dps_pkg;

    localparam int DPS_MAX_PROCS = 16;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_RUN = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED = 3'd0,
        ST_FULL  = 3'd1,
        ST_ZERO  = 3'd2,
        ST_RUN   = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    typedef struct packed {
        logic               op;
        logic [31:0]        tag;
        logic [15:0]        burst_time;
        logic signed [15:0] prio_in;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [31:0]        run_tag;
        logic [15:0]        remaining_time;
        logic signed [15:0] prio_after;
        logic               finished;
        logic [4:0]         ready_count;
    } result_t;

    typedef struct packed {
        logic [31:0]        tag;
        logic [15:0]        rem_time;
        logic signed [15:0] prio;
    } entry_t;

endpackage

@@ design/dps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/dynamic_priority_scheduler.sv @@
// Top level of the dynamic priority scheduler: sequencer over a circular ready table.
//
//   channel  direction  handshake                  payload
//   cmd      in         cmd_valid / cmd_stall      cmd_t    (op, tag, burst_time, prio_in)
//   result   out        result_valid / result_stall result_t (status ... ready_count)
//
// An add moves up n entries from the tail, one per cycle (n at most MAX_PROCS - 1), then
// writes its entry; a run charges the head entry and re-inserts it the same way unless it
// finishes. Rejected adds, runs on an empty table and finished runs skip the walk.
// Reset clears the entry count and head and tail pointers; the table needs no clearing pass.
// cmd_stall is high while an item is in work; a stalled result holds the block in its
// final state until the result register frees up, then the next item is accepted.
module dynamic_priority_scheduler
    import dps_pkg::*;
#(
    parameter int MAX_PROCS = DPS_MAX_PROCS
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_stall,
    input  cmd_t    cmd,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_WALK,
        S_PLACE,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [IW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            result_valid_reg, result_valid_next;
    result_t         result_reg, result_next;

    logic [IW-1:0]   rp_reg, rp_next;
    logic [IW-1:0]   wp_reg, wp_next;
    logic [CW-1:0]   left_reg, left_next;
    entry_t          new_reg, new_next;
    result_t         res_reg, res_next;

    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    entry_t          wr_data;
    logic [IW-1:0]   rd_addr;
    logic [63:0]     rd_raw;
    entry_t          rd_entry;
    logic [IW-1:0]   tail_dec;
    logic [15:0]     time_dec;
    logic signed [15:0] prio_dec;
    logic [CW+4:0]   count_ext;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] p);
        return (p == IW'(MAX_PROCS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] p);
        return (p == '0) ? IW'(MAX_PROCS - 1) : p - 1'b1;
    endfunction

    dps_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_entry  = entry_t'(rd_raw);
    assign tail_dec  = idx_dec(tail_reg);
    assign time_dec  = rd_entry.rem_time - 16'd1;
    assign prio_dec  = (rd_entry.prio == -16'sd32768) ? rd_entry.prio : rd_entry.prio - 16'sd1;
    assign count_ext = {5'b0, count_reg};

    assign cmd_stall    = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        rp_next           = rp_reg;
        wp_next           = wp_reg;
        left_next         = left_reg;
        new_next          = new_reg;
        res_next          = res_reg;
        wr_en             = 1'b0;
        wr_addr           = wp_reg;
        wr_data           = new_reg;
        rd_addr           = tail_dec;

        // drop a result once it is taken
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = (cmd.op == OP_RUN) ? head_reg : tail_dec;
                if (cmd_valid)
                begin
                    res_next = '0;
                    if (cmd.op == OP_ADD)
                    begin
                        new_next  = '{tag: cmd.tag, rem_time: cmd.burst_time, prio: cmd.prio_in};
                        wp_next   = tail_reg;
                        rp_next   = tail_dec;
                        left_next = count_reg;
                        if (cmd.burst_time == 16'd0)
                        begin
                            res_next.status = ST_ZERO;
                            state_next      = S_DONE;
                        end
                        else if (count_reg == CW'(MAX_PROCS))
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            res_next.status = ST_ADDED;
                            state_next      = (count_reg == '0) ? S_PLACE : S_WALK;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.status = ST_EMPTY;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RUN;
                    end
                end
            end

            S_RUN:
            begin
                // head entry is on the read port; charge it one slice
                res_next.status         = ST_RUN;
                res_next.run_tag        = rd_entry.tag;
                res_next.remaining_time = time_dec;
                res_next.prio_after     = prio_dec;
                res_next.finished       = (time_dec == 16'd0);
                head_next               = idx_inc(head_reg);
                count_next              = count_reg - 1'b1;
                new_next  = '{tag: rd_entry.tag, rem_time: time_dec, prio: prio_dec};
                wp_next   = tail_reg;
                rp_next   = tail_dec;
                left_next = count_reg - 1'b1;
                if (time_dec == 16'd0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = (count_reg == CW'(1)) ? S_PLACE : S_WALK;
                end
            end

            S_WALK:
            begin
                // move lower-or-equal entries up one slot, walking from the tail
                if (!(new_reg.prio < rd_entry.prio))
                begin
                    wr_en     = 1'b1;
                    wr_addr   = wp_reg;
                    wr_data   = rd_entry;
                    wp_next   = rp_reg;
                    rp_next   = idx_dec(rp_reg);
                    rd_addr   = idx_dec(rp_reg);
                    left_next = left_reg - 1'b1;
                    if (left_reg == CW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    tail_next  = idx_inc(tail_reg);
                    state_next = S_DONE;
                end
            end

            S_PLACE:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
                tail_next  = idx_inc(tail_reg);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next             = res_reg;
                    result_next.ready_count = count_ext[4:0];
                    result_valid_next       = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        rp_reg     <= rp_next;
        wp_reg     <= wp_next;
        left_reg   <= left_next;
        new_reg    <= new_next;
        res_reg    <= res_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_PROCS))
        else $error("entry count exceeds table depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && count_reg == '0) |-> (head_reg == tail_reg))
        else $error("head and tail disagree on an empty table");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("table written while idle");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the final state");

    a_finished_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.finished) |-> (result_reg.remaining_time == 16'd0))
        else $error("finished process reports remaining time");
`endif

endmodule
